FILE: sv/mfp_pkg.sv
// Shared constants and types of the Mercator forward projection unit.
package mfp_pkg;

  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam logic signed [63:0] LN2_Q56 = 64'sh00B1_7217_F7D1_CF7A;
  // half colatitude in radians per input unit, scaled by 2^92
  localparam logic [63:0] K_HALF_RAD = (PI_Q60 / 64'd45) * 64'd128
                                       + ((PI_Q60 % 64'd45) * 64'd128) / 64'd45;
  // floor(2^96 / pi in Q60), quotient estimate for the division by pi
  localparam logic [127:0] PI_RECIP_W = (128'd1 << 96) / {64'd0, PI_Q60};
  localparam logic [63:0]  PI_RECIP   = PI_RECIP_W[63:0];
  localparam logic [30:0] QUARTER_TURN = 31'd377487360;
  localparam logic [63:0] Y_LIMIT = 64'd2147483647;
  localparam logic [31:0] ECC_RESET = 32'd351410749;
  localparam logic REG_ECC = 1'b0;

  typedef struct packed {
    logic        lat_neg;
    logic        pole;
    logic [31:0] x_norm;
  } mfp_tag_t;

  localparam int TAGW = $bits(mfp_tag_t);

endpackage

FILE: sv/mfp_mulq.sv
// Two-stage 64x64 multiplier giving the product shifted right by SH, truncated to 64 bits.
module mfp_mulq #(
  parameter int SH  = 60,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  logic [63:0]    a_i,
  input  logic [63:0]    b_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [63:0]    p_o,
  output logic [SBW-1:0] sb_o
);

  logic [63:0]    ll_r, lh_r, hl_r, hh_r;
  logic [SBW-1:0] sb1_r;
  logic           v1_r;
  logic [127:0]   full;
  logic [63:0]    p_r;
  logic [SBW-1:0] sb2_r;
  logic           v2_r;

  always_ff @(posedge clk) begin
    ll_r  <= a_i[31:0] * b_i[31:0];
    lh_r  <= a_i[31:0] * b_i[63:32];
    hl_r  <= a_i[63:32] * b_i[31:0];
    hh_r  <= a_i[63:32] * b_i[63:32];
    sb1_r <= sb_i;
    p_r   <= full[SH+63:SH];
    sb2_r <= sb1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  assign full = {hh_r, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0};

  assign vld_o = v2_r;
  assign p_o   = p_r;
  assign sb_o  = sb2_r;

endmodule

FILE: sv/mfp_cdiv.sv
// Floor division of a 64-bit value by the constant D: reciprocal multiply and one correction.
module mfp_cdiv #(
  parameter int D   = 3,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  logic [63:0]    t_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [63:0]    q_o,
  output logic [SBW-1:0] sb_o
);

  localparam logic [63:0] DV    = 64'(D);
  localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / DV;

  logic           v1;
  logic [63:0]    q0;
  logic [SBW+63:0] sb1;
  logic [63:0]    q0_r, rem_r, q_r;
  logic [SBW-1:0] sb3_r, sb4_r;
  logic           v3_r, v4_r;

  // estimate is the true quotient or one below it
  mfp_mulq #(.SH(64), .SBW(SBW + 64)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_i),
    .a_i   (t_i),
    .b_i   (RECIP),
    .sb_i  ({t_i, sb_i}),
    .vld_o (v1),
    .p_o   (q0),
    .sb_o  (sb1)
  );

  always_ff @(posedge clk) begin
    q0_r  <= q0;
    rem_r <= sb1[SBW+63:SBW] - q0 * DV;
    sb3_r <= sb1[SBW-1:0];
    q_r   <= (rem_r >= DV) ? q0_r + 64'd1 : q0_r;
    sb4_r <= sb3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v1;
      v4_r <= v3_r;
    end
  end

  assign vld_o = v4_r;
  assign q_o   = q_r;
  assign sb_o  = sb4_r;

endmodule

FILE: sv/mfp_divr.sv
// Pipelined restoring divider: round(n * 2^EXTRA / d), one quotient bit per stage.
module mfp_divr #(
  parameter int EXTRA = 60,
  parameter int SBW   = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  logic [63:0]    n_i,
  input  logic [63:0]    d_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [63:0]    q_o,
  output logic [SBW-1:0] sb_o
);

  localparam int N = 64 + EXTRA;

  logic [63:0]    rem_r [0:N-1];
  logic [63:0]    quo_r [0:N-1];
  logic [63:0]    num_r [0:N-1];
  logic [63:0]    den_r [0:N-1];
  logic [SBW-1:0] sb_r  [0:N-1];
  logic           v_r   [0:N-1];
  logic [63:0]    q_r;
  logic [SBW-1:0] sbo_r;
  logic           vo_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [63:0]    rin, qin, nin, din, rr;
    logic [SBW-1:0] sbin;
    logic           vin, ge;
    if (i == 0) begin : g_first
      assign rin  = 64'd0;
      assign qin  = 64'd0;
      assign nin  = n_i;
      assign din  = d_i;
      assign sbin = sb_i;
      assign vin  = vld_i;
    end else begin : g_next
      assign rin  = rem_r[i-1];
      assign qin  = quo_r[i-1];
      assign nin  = num_r[i-1];
      assign din  = den_r[i-1];
      assign sbin = sb_r[i-1];
      assign vin  = v_r[i-1];
    end
    // dividend bits run out after 64 shifts and zeros follow
    assign rr = {rin[62:0], nin[63]};
    assign ge = (rr >= din);
    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? rr - din : rr;
      quo_r[i] <= {qin[62:0], ge};
      num_r[i] <= {nin[62:0], 1'b0};
      den_r[i] <= din;
      sb_r[i]  <= sbin;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vin;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= ({rem_r[N-1][62:0], 1'b0} >= den_r[N-1]) ? quo_r[N-1] + 64'd1 : quo_r[N-1];
    sbo_r <= sb_r[N-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[N-1];
    end
  end

  assign vld_o = vo_r;
  assign q_o   = q_r;
  assign sb_o  = sbo_r;

endmodule

FILE: sv/mfp_ln.sv
// Pipelined natural logarithm: Q60 in, signed Q56 out, atanh series through the z^41 term.
module mfp_ln
  import mfp_pkg::*;
#(
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  input  logic [63:0]         x_i,
  input  logic [SBW-1:0]      sb_i,
  output logic                vld_o,
  output logic signed [63:0]  ln_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int NT  = 20;
  localparam int IW  = 64 + 64 + 6 + SBW;
  localparam int CW  = 64 + IW;

  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  logic [63:0]    x1_r, m2_r, num3_r, den3_r;
  logic [5:0]     n1_r, n2_r, n3_r;
  logic [SBW-1:0] sb1_r, sb2_r, sb3_r;
  logic           v1_r, v2_r, v3_r;

  logic [63:0]       z;
  logic [6+SBW-1:0]  sbz;
  logic              vz;
  logic [63:0]       z2;
  logic [64+6+SBW-1:0] sbz2;
  logic              vz2;

  logic [63:0]    t_w   [0:NT];
  logic [63:0]    sum_w [0:NT];
  logic [63:0]    zz_w  [0:NT];
  logic [5:0]     n_w   [0:NT];
  logic [SBW-1:0] sb_w  [0:NT];
  logic           v_w   [0:NT];

  logic [63:0]          sum4;
  logic signed [7:0]    ex;
  logic signed [63:0]   res_r;
  logic [SBW-1:0]       sbo_r;
  logic                 vo_r;

  always_ff @(posedge clk) begin
    x1_r   <= (x_i == 64'd0) ? 64'd1 : x_i;
    n1_r   <= msb_pos((x_i == 64'd0) ? 64'd1 : x_i);
    sb1_r  <= sb_i;
    m2_r   <= (n1_r > 6'd60) ? x1_r >> (n1_r - 6'd60) : x1_r << (6'd60 - n1_r);
    n2_r   <= n1_r;
    sb2_r  <= sb1_r;
    num3_r <= m2_r - Q60_ONE;
    den3_r <= m2_r + Q60_ONE;
    n3_r   <= n2_r;
    sb3_r  <= sb2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // z = (m - 1) / (m + 1)
  mfp_divr #(.EXTRA(60), .SBW(6 + SBW)) u_zdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v3_r),
    .n_i   (num3_r),
    .d_i   (den3_r),
    .sb_i  ({n3_r, sb3_r}),
    .vld_o (vz),
    .q_o   (z),
    .sb_o  (sbz)
  );

  mfp_mulq #(.SH(60), .SBW(64 + 6 + SBW)) u_zsq (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vz),
    .a_i   (z),
    .b_i   (z),
    .sb_i  ({z, sbz}),
    .vld_o (vz2),
    .p_o   (z2),
    .sb_o  (sbz2)
  );

  assign t_w[0]   = sbz2[64+6+SBW-1:6+SBW];
  assign sum_w[0] = sbz2[64+6+SBW-1:6+SBW];
  assign zz_w[0]  = z2;
  assign n_w[0]   = sbz2[6+SBW-1:SBW];
  assign sb_w[0]  = sbz2[SBW-1:0];
  assign v_w[0]   = vz2;

  for (genvar k = 1; k <= NT; k++) begin : g_term
    logic [63:0]   tm, q;
    logic [IW-1:0] sbm;
    logic [CW-1:0] sbq;
    logic          vm, vq;

    mfp_mulq #(.SH(60), .SBW(IW)) u_pow (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (v_w[k-1]),
      .a_i   (t_w[k-1]),
      .b_i   (zz_w[k-1]),
      .sb_i  ({sum_w[k-1], zz_w[k-1], n_w[k-1], sb_w[k-1]}),
      .vld_o (vm),
      .p_o   (tm),
      .sb_o  (sbm)
    );

    mfp_cdiv #(.D(2 * k + 1), .SBW(CW)) u_odd (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vm),
      .t_i   (tm),
      .sb_i  ({tm, sbm}),
      .vld_o (vq),
      .q_o   (q),
      .sb_o  (sbq)
    );

    assign t_w[k]   = sbq[CW-1:IW];
    assign sum_w[k] = sbq[IW-1:64+6+SBW] + q;
    assign zz_w[k]  = sbq[64+6+SBW-1:6+SBW];
    assign n_w[k]   = sbq[6+SBW-1:SBW];
    assign sb_w[k]  = sbq[SBW-1:0];
    assign v_w[k]   = vq;
  end

  assign sum4 = sum_w[NT] + 64'd4;
  assign ex   = $signed({2'b00, n_w[NT]}) - 8'sd60;

  always_ff @(posedge clk) begin
    res_r <= $signed({3'b000, sum4[63:3]}) + 64'(ex) * LN2_Q56;
    sbo_r <= sb_w[NT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_w[NT];
    end
  end

  assign vld_o = vo_r;
  assign ln_o  = res_r;
  assign sb_o  = sbo_r;

endmodule

FILE: sv/mercator_forward_projection_unit.sv
// Top level of the ellipsoidal Mercator forward projection pipeline.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  ------------------------------
//  input     in_longitude, in_latitude                    start && !busy
//  result    out_x_norm, out_y_norm, out_saturated        out_valid, one cycle, no stall
//  config    cfg_psel/penable/pwrite/paddr/pwdata/prdata  APB, eccentricity at 0x0
//
// One item enters every cycle; busy is tied low. After the accepting edge a result passes
// through capture, the x division and the half angle, the twelve Taylor sections, the
// squares and e sin lat, the logarithms (the restoring divider for z among them), the
// eccentricity term and the division by pi, and then the result strobe rises.
// Reset clears the valid bits only and loads the WGS84 eccentricity. The receiver cannot
// stall, so nothing in the pipeline ever holds.
module mercator_forward_projection_unit
  import mfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_longitude,
  input  logic signed [29:0] in_latitude,
  output logic               out_valid,
  output logic signed [31:0] out_x_norm,
  output logic signed [31:0] out_y_norm,
  output logic               out_saturated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int NK  = 12;
  localparam int SCW = 64 * 3 + TAGW;
  localparam int HCW = 64 * 2 + TAGW;

  logic [31:0] ecc_r;
  logic [63:0] ecc;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_r <= ECC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_ECC) begin
      ecc_r <= cfg_pwdata;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ECC) ? ecc_r : 32'd0;
  assign busy       = 1'b0;
  assign ecc        = {32'd0, ecc_r};

  // ---- input capture and sign handling
  logic [30:0] lonv_r;
  logic [29:0] latv_r;
  logic        v0_r;
  logic        lon_neg, lat_neg, pole;
  logic [31:0] lon_mag;
  logic [30:0] lat_mag, colat;
  logic [37:0] xnum_r;
  logic [29:0] colat_r;
  logic        lon_neg_r, lat_neg_r, pole_r, v1_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lonv_r <= in_longitude;
      latv_r <= in_latitude;
    end
  end

  assign lon_neg = lonv_r[30];
  assign lat_neg = latv_r[29];
  assign lon_mag = lon_neg ? 32'h8000_0000 - {1'b0, lonv_r} : {1'b0, lonv_r};
  assign lat_mag = lat_neg ? 31'h4000_0000 - {1'b0, latv_r} : {1'b0, latv_r};
  assign pole    = (lat_mag >= QUARTER_TURN);
  assign colat   = QUARTER_TURN - lat_mag;

  always_ff @(posedge clk) begin
    xnum_r    <= {lon_mag, 6'd0} + 38'd22;
    colat_r   <= colat[29:0];
    lon_neg_r <= lon_neg;
    lat_neg_r <= lat_neg;
    pole_r    <= pole;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
    end
  end

  // ---- x: lon * 64 / 45, then the half colatitude
  logic [63:0] xq;
  logic [32:0] sbx;
  logic        vx;
  mfp_tag_t    tag_x;
  logic [63:0] h;
  logic [TAGW-1:0] sbh;
  logic        vh;

  mfp_cdiv #(.D(45), .SBW(33)) u_xdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v1_r),
    .t_i   ({26'd0, xnum_r}),
    .sb_i  ({colat_r, lon_neg_r, lat_neg_r, pole_r}),
    .vld_o (vx),
    .q_o   (xq),
    .sb_o  (sbx)
  );

  assign tag_x.lat_neg = sbx[1];
  assign tag_x.pole    = sbx[0];
  assign tag_x.x_norm  = sbx[2] ? 32'd0 - xq[31:0] : xq[31:0];

  mfp_mulq #(.SH(32), .SBW(TAGW)) u_half (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vx),
    .a_i   ({34'd0, sbx[32:3]}),
    .b_i   (K_HALF_RAD),
    .sb_i  (tag_x),
    .vld_o (vh),
    .p_o   (h),
    .sb_o  (sbh)
  );

  // ---- sin and cos of the half colatitude, one Taylor term per section
  logic [63:0]          hsq;
  logic [64+TAGW-1:0]   sbhsq;
  logic                 vhsq;

  mfp_mulq #(.SH(60), .SBW(64 + TAGW)) u_hsq (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vh),
    .a_i   (h),
    .b_i   (h),
    .sb_i  ({h, sbh}),
    .vld_o (vhsq),
    .p_o   (hsq),
    .sb_o  (sbhsq)
  );

  logic [63:0]     ts_w [0:NK];
  logic [63:0]     tc_w [0:NK];
  logic [63:0]     ss_w [0:NK];
  logic [63:0]     sc_w [0:NK];
  logic [63:0]     h2_w [0:NK];
  logic [TAGW-1:0] tg_w [0:NK];
  logic            v_w  [0:NK];

  assign ts_w[0] = sbhsq[64+TAGW-1:TAGW];
  assign ss_w[0] = sbhsq[64+TAGW-1:TAGW];
  assign tc_w[0] = Q60_ONE;
  assign sc_w[0] = Q60_ONE;
  assign h2_w[0] = hsq;
  assign tg_w[0] = sbhsq[TAGW-1:0];
  assign v_w[0]  = vhsq;

  for (genvar k = 1; k <= NK; k++) begin : g_taylor
    logic [63:0]    ms, mc, qs, qc;
    logic [SCW-1:0] sbm;
    logic [SCW-1:0] sbq;
    logic           vm, vq;

    mfp_mulq #(.SH(60), .SBW(SCW)) u_ms (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (v_w[k-1]),
      .a_i   (ts_w[k-1]),
      .b_i   (h2_w[k-1]),
      .sb_i  ({ss_w[k-1], sc_w[k-1], h2_w[k-1], tg_w[k-1]}),
      .vld_o (vm),
      .p_o   (ms),
      .sb_o  (sbm)
    );

    mfp_mulq #(.SH(60), .SBW(1)) u_mc (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (v_w[k-1]),
      .a_i   (tc_w[k-1]),
      .b_i   (h2_w[k-1]),
      .sb_i  (1'b0),
      .vld_o (),
      .p_o   (mc),
      .sb_o  ()
    );

    mfp_cdiv #(.D((2 * k) * (2 * k + 1)), .SBW(SCW)) u_ds (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vm),
      .t_i   (ms),
      .sb_i  (sbm),
      .vld_o (vq),
      .q_o   (qs),
      .sb_o  (sbq)
    );

    mfp_cdiv #(.D((2 * k - 1) * (2 * k)), .SBW(1)) u_dc (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vm),
      .t_i   (mc),
      .sb_i  (1'b0),
      .vld_o (),
      .q_o   (qc),
      .sb_o  ()
    );

    // odd terms subtract, even terms add
    if (k % 2 == 1) begin : g_sub
      assign ss_w[k] = sbq[SCW-1:SCW-64] - qs;
      assign sc_w[k] = sbq[SCW-65:SCW-128] - qc;
    end else begin : g_add
      assign ss_w[k] = sbq[SCW-1:SCW-64] + qs;
      assign sc_w[k] = sbq[SCW-65:SCW-128] + qc;
    end
    assign ts_w[k] = qs;
    assign tc_w[k] = qc;
    assign h2_w[k] = sbq[SCW-129:TAGW];
    assign tg_w[k] = sbq[TAGW-1:0];
    assign v_w[k]  = vq;
  end

  // ---- sin lat = cos^2 - sin^2, 1 - sin lat = 2 sin^2
  logic [63:0]    s2, c2;
  logic [HCW-1:0] sbsq;
  logic           vsq;
  logic [63:0]    s_r, oms_r, sh_r, ch_r;
  logic [TAGW-1:0] tg_r;
  logic           vr1_r;

  mfp_mulq #(.SH(60), .SBW(HCW)) u_s2 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v_w[NK]),
    .a_i   (ss_w[NK]),
    .b_i   (ss_w[NK]),
    .sb_i  ({ss_w[NK], sc_w[NK], tg_w[NK]}),
    .vld_o (vsq),
    .p_o   (s2),
    .sb_o  (sbsq)
  );

  mfp_mulq #(.SH(60), .SBW(1)) u_c2 (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (v_w[NK]),
    .a_i   (sc_w[NK]),
    .b_i   (sc_w[NK]),
    .sb_i  (1'b0),
    .vld_o (),
    .p_o   (c2),
    .sb_o  ()
  );

  always_ff @(posedge clk) begin
    s_r   <= (c2 > s2) ? c2 - s2 : 64'd0;
    oms_r <= {s2[62:0], 1'b0};
    sh_r  <= sbsq[HCW-1:HCW-64];
    ch_r  <= sbsq[HCW-65:TAGW];
    tg_r  <= sbsq[TAGW-1:0];
  end

  // ---- 1 + e sin lat and 1 - e sin lat
  logic [63:0]    u, eo;
  logic [HCW-1:0] sbu;
  logic           vu;
  logic [63:0]    onepu_r, omu_r, sh2_r, ch2_r;
  logic [TAGW-1:0] tg2_r;
  logic           vr2_r;

  mfp_mulq #(.SH(32), .SBW(HCW)) u_u (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vr1_r),
    .a_i   (s_r),
    .b_i   (ecc),
    .sb_i  ({sh_r, ch_r, tg_r}),
    .vld_o (vu),
    .p_o   (u),
    .sb_o  (sbu)
  );

  mfp_mulq #(.SH(32), .SBW(1)) u_eo (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vr1_r),
    .a_i   (ecc),
    .b_i   (oms_r),
    .sb_i  (1'b0),
    .vld_o (),
    .p_o   (eo),
    .sb_o  ()
  );

  always_ff @(posedge clk) begin
    onepu_r <= Q60_ONE + u;
    omu_r   <= {3'd0, 33'h1_0000_0000 - {1'b0, ecc_r}, 28'd0} + eo;
    sh2_r   <= sbu[HCW-1:HCW-64];
    ch2_r   <= sbu[HCW-65:TAGW];
    tg2_r   <= sbu[TAGW-1:0];
  end

  // ---- four logarithms side by side
  logic signed [63:0] la, lb, lc, ld;
  logic [TAGW-1:0]    sbl;
  logic               vl;

  mfp_ln #(.SBW(TAGW)) u_ln_c (
    .clk (clk), .rst_n (rst_n), .vld_i (vr2_r), .x_i (ch2_r), .sb_i (tg2_r),
    .vld_o (vl), .ln_o (la), .sb_o (sbl)
  );
  mfp_ln #(.SBW(1)) u_ln_s (
    .clk (clk), .rst_n (rst_n), .vld_i (vr2_r), .x_i (sh2_r), .sb_i (1'b0),
    .vld_o (), .ln_o (lb), .sb_o ()
  );
  mfp_ln #(.SBW(1)) u_ln_p (
    .clk (clk), .rst_n (rst_n), .vld_i (vr2_r), .x_i (onepu_r), .sb_i (1'b0),
    .vld_o (), .ln_o (lc), .sb_o ()
  );
  mfp_ln #(.SBW(1)) u_ln_m (
    .clk (clk), .rst_n (rst_n), .vld_i (vr2_r), .x_i (omu_r), .sb_i (1'b0),
    .vld_o (), .ln_o (ld), .sb_o ()
  );

  // ---- northing in Q56
  logic signed [63:0] dl;
  logic signed [63:0] y_r;
  logic [63:0]        b_r;
  logic [TAGW-1:0]    tg3_r;
  logic               vr3_r;
  logic [63:0]        em;
  logic [64+TAGW-1:0] sbe;
  logic               ve;
  logic signed [63:0] y2;
  logic [63:0]        yc_r;
  logic [TAGW-1:0]    tg4_r;
  logic               vr4_r;

  assign dl = lc - ld;

  always_ff @(posedge clk) begin
    y_r   <= la - lb;
    b_r   <= dl[63] ? 64'd0 : {1'b0, dl[63:1]};
    tg3_r <= sbl;
  end

  mfp_mulq #(.SH(32), .SBW(64 + TAGW)) u_em (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vr3_r),
    .a_i   (b_r),
    .b_i   (ecc),
    .sb_i  ({y_r, tg3_r}),
    .vld_o (ve),
    .p_o   (em),
    .sb_o  (sbe)
  );

  assign y2 = (ecc_r != 32'd0) ? $signed(sbe[64+TAGW-1:TAGW]) - $signed(em)
                               : $signed(sbe[64+TAGW-1:TAGW]);

  always_ff @(posedge clk) begin
    yc_r  <= y2[63] ? 64'd0 : y2;
    tg4_r <= sbe[TAGW-1:0];
  end

  // ---- divide by pi into Q28 and saturate
  // the reciprocal estimate is exact or one short; the low 64 bits of the
  // remainder are enough to correct it and to round
  logic [63:0]        q0;
  logic [32+TAGW-1:0] sbq0;
  logic               vq0;
  logic [63:0]        qp;
  logic [96+TAGW-1:0] sbqp;
  logic               vqp;
  logic [63:0]        r0_r, q0_r, r1_r, q1_r, yq_r;
  logic [TAGW-1:0]    tg5_r, tg6_r, tg7_r;
  logic               vr5_r, vr6_r, vr7_r;
  mfp_tag_t           tg_d;
  logic [31:0]        ymag;
  logic               sat;
  logic [31:0]        xo_r, yo_r;
  logic               sat_r, vo_r;

  mfp_mulq #(.SH(64), .SBW(32 + TAGW)) u_pirq (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vr4_r),
    .a_i   (yc_r),
    .b_i   (PI_RECIP),
    .sb_i  ({yc_r[31:0], tg4_r}),
    .vld_o (vq0),
    .p_o   (q0),
    .sb_o  (sbq0)
  );

  mfp_mulq #(.SH(0), .SBW(96 + TAGW)) u_piqp (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vq0),
    .a_i   (q0),
    .b_i   (PI_Q60),
    .sb_i  ({q0, sbq0}),
    .vld_o (vqp),
    .p_o   (qp),
    .sb_o  (sbqp)
  );

  always_ff @(posedge clk) begin
    r0_r  <= {sbqp[32+TAGW-1:TAGW], 32'd0} - qp;
    q0_r  <= sbqp[96+TAGW-1:32+TAGW];
    tg5_r <= sbqp[TAGW-1:0];
    r1_r  <= (r0_r >= PI_Q60) ? r0_r - PI_Q60 : r0_r;
    q1_r  <= (r0_r >= PI_Q60) ? q0_r + 64'd1 : q0_r;
    tg6_r <= tg5_r;
    yq_r  <= ({r1_r[62:0], 1'b0} >= PI_Q60) ? q1_r + 64'd1 : q1_r;
    tg7_r <= tg6_r;
  end

  assign tg_d = tg7_r;
  assign sat  = tg_d.pole || (yq_r > Y_LIMIT);
  assign ymag = sat ? Y_LIMIT[31:0] : yq_r[31:0];

  always_ff @(posedge clk) begin
    xo_r  <= tg_d.x_norm;
    yo_r  <= tg_d.lat_neg ? 32'd0 - ymag : ymag;
    sat_r <= sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr1_r <= 1'b0;
      vr2_r <= 1'b0;
      vr3_r <= 1'b0;
      vr4_r <= 1'b0;
      vr5_r <= 1'b0;
      vr6_r <= 1'b0;
      vr7_r <= 1'b0;
      vo_r  <= 1'b0;
    end else begin
      vr1_r <= vsq;
      vr2_r <= vu;
      vr3_r <= vl;
      vr4_r <= ve;
      vr5_r <= vqp;
      vr6_r <= vr5_r;
      vr7_r <= vr6_r;
      vo_r  <= vr7_r;
    end
  end

  assign out_valid     = vo_r;
  assign out_x_norm    = xo_r;
  assign out_y_norm    = yo_r;
  assign out_saturated = sat_r;

  // ---- checks
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_y_norm == 32'sh7FFF_FFFF || out_y_norm == 32'sh8000_0001))
    else $error("saturated result not at the clamp value");

  a_no_min_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_y_norm != 32'sh8000_0000)
    else $error("northing outside the symmetric range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe straight after reset");

  a_ecc_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_ECC |=>
      ecc_r == $past(cfg_pwdata))
    else $error("eccentricity transfer not taken");

endmodule

FILE: tb/sv/mercator_forward_projection_unit_chk.sv
// Result checker for the Mercator forward projection unit: prediction and comparison.
module mercator_forward_projection_unit_chk
  import mfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [30:0] in_longitude,
  input  logic signed [29:0] in_latitude,
  input  logic               out_valid,
  input  logic signed [31:0] out_x_norm,
  input  logic signed [31:0] out_y_norm,
  input  logic               out_saturated,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic signed [31:0] x_norm;
    logic signed [31:0] y_norm;
    logic               saturated;
  } mercator_xy_t;

  mercator_xy_t pending_xy[$];
  logic [31:0]  ecc;

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_rnd(input logic [63:0] n, input int unsigned extra,
                                          input logic [63:0] d);
    logic [127:0] num, q, r;
    num = {64'd0, n} << extra;
    q = num / {64'd0, d};
    r = num % {64'd0, d};
    if (2 * r >= {64'd0, d}) q = q + 1;
    return q[63:0];
  endfunction

  // natural log, Q60 in, Q56 out
  function automatic longint ln_q56(input logic [63:0] x);
    int          n;
    logic [63:0] m, z, z2, t, sum, xv;
    xv = (x == 0) ? 64'd1 : x;
    n = 63;
    while (!xv[n]) n--;
    m = (n > 60) ? (xv >> (n - 60)) : (xv << (60 - n));
    z = div_rnd(m - Q60_ONE, 60, m + Q60_ONE);
    z2 = mul_shr(z, z, 60);
    sum = z;
    t = z;
    for (int k = 1; k <= 20; k++) begin
      t = mul_shr(t, z2, 60);
      sum = sum + t / (2 * k + 1);
    end
    return longint'((sum + 64'd4) >> 3) + longint'(n - 60) * LN2_Q56;
  endfunction

  function automatic void half_sin_cos(input logic [63:0] h, output logic [63:0] s,
                                       output logic [63:0] c);
    logic [63:0] h2, ts, tc;
    h2 = mul_shr(h, h, 60);
    ts = h;
    s = h;
    tc = Q60_ONE;
    c = Q60_ONE;
    for (int k = 1; k <= 12; k++) begin
      ts = mul_shr(ts, h2, 60) / ((2 * k) * (2 * k + 1));
      tc = mul_shr(tc, h2, 60) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
  endfunction

  function automatic mercator_xy_t project(input logic [30:0] lon, input logic [29:0] lat,
                                           input logic [31:0] e);
    mercator_xy_t r;
    logic [63:0]  lon_mag, lat_mag, xq, yq, colat, h, sh, ch, s2, c2, s, oms, u, onepu, omu;
    longint       y, d;
    lon_mag = lon[30] ? (64'h8000_0000 - {33'd0, lon}) : {33'd0, lon};
    lat_mag = lat[29] ? (64'h4000_0000 - {34'd0, lat}) : {34'd0, lat};
    xq = (lon_mag * 64 + 22) / 45;
    r.x_norm = lon[30] ? -xq[31:0] : xq[31:0];
    r.saturated = 1'b0;
    if (lat_mag >= {33'd0, QUARTER_TURN}) begin
      yq = Y_LIMIT;
      r.saturated = 1'b1;
    end else begin
      colat = {33'd0, QUARTER_TURN} - lat_mag;
      h = mul_shr(colat, K_HALF_RAD, 32);
      half_sin_cos(h, sh, ch);
      s2 = mul_shr(sh, sh, 60);
      c2 = mul_shr(ch, ch, 60);
      s = (c2 > s2) ? c2 - s2 : 64'd0;
      oms = 2 * s2;
      y = ln_q56(ch) - ln_q56(sh);
      if (e != 0) begin
        u = mul_shr(s, {32'd0, e}, 32);
        onepu = Q60_ONE + u;
        omu = ((64'h1_0000_0000 - {32'd0, e}) << 28) + mul_shr({32'd0, e}, oms, 32);
        d = ln_q56(onepu) - ln_q56(omu);
        if (d < 0) d = 0;
        y = y - longint'(mul_shr(64'(d) >> 1, {32'd0, e}, 32));
      end
      if (y < 0) y = 0;
      yq = div_rnd(64'(y), 32, PI_Q60);
      if (yq > Y_LIMIT) begin
        yq = Y_LIMIT;
        r.saturated = 1'b1;
      end
    end
    r.y_norm = lat[29] ? -yq[31:0] : yq[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    ecc = ECC_RESET;
  end

  always @(posedge clk) begin
    mercator_xy_t want;
    if (!rst_n) begin
      ecc = ECC_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == REG_ECC)
        ecc = cfg_pwdata;
      if (start && !busy) pending_xy.push_back(project(in_longitude, in_latitude, ecc));
      if (out_valid) begin
        if (pending_xy.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          want = pending_xy.pop_front();
          if (out_x_norm !== want.x_norm) report_mismatch("x_norm", out_x_norm, want.x_norm);
          if (out_y_norm !== want.y_norm) report_mismatch("y_norm", out_y_norm, want.y_norm);
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", out_saturated, want.saturated);
        end
      end
    end
    outstanding = pending_xy.size();
  end

endmodule

FILE: tb/sv/mercator_forward_projection_unit_tb.sv
// Stimulus and verdict for the Mercator forward projection unit.
module mercator_forward_projection_unit_tb
  import mfp_pkg::*;
();

  localparam int LON_MAX = 754974720;
  localparam int LAT_MAX = 377487360;
  localparam int CYCLE_LIMIT = 300000;

  logic               clk, rst_n, start, busy;
  logic signed [30:0] in_longitude;
  logic signed [29:0] in_latitude;
  logic               out_valid, out_saturated;
  logic signed [31:0] out_x_norm, out_y_norm;
  logic               cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata, cfg_prdata;
  int                 mismatches, outstanding, cycles;
  int                 burst_left;

  mercator_forward_projection_unit uut (.*);

  mercator_forward_projection_unit_chk chk (
    .clk, .rst_n, .start, .busy, .in_longitude, .in_latitude,
    .out_valid, .out_x_norm, .out_y_norm, .out_saturated,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one transfer; start stays high across a burst, drops for a random gap after it
  task automatic send_coord(input int lon, input int lat);
    start <= 1'b1;
    in_longitude <= 31'(lon);
    in_latitude <= 30'(lat);
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pole_cases;
    send_coord(0, LAT_MAX);
    send_coord(0, -LAT_MAX);
    send_coord(LON_MAX, LAT_MAX - 1);
    send_coord(-LON_MAX, -LAT_MAX + 1);
    send_coord(1, 1);
    send_coord(-1, -1);
  endtask

  task automatic random_run(input int count);
    int lat;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0:       lat = LAT_MAX - int'($urandom_range(0, 70000));
        1:       lat = int'($urandom_range(0, 4096));
        default: lat = int'($urandom_range(0, LAT_MAX));
      endcase
      if ($urandom_range(0, 1)) lat = -lat;
      send_coord(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX, lat);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_longitude = '0;
    in_latitude = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cycles = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases and a random run, reset eccentricity
    pole_cases();
    send_coord(LON_MAX, 0);
    send_coord(-LON_MAX, 0);
    send_coord(0, 0);
    send_coord(LON_MAX, LAT_MAX - 16);
    send_coord(-LON_MAX, -(LAT_MAX - 16));
    send_coord(-2, LAT_MAX - 2);
    send_coord(12345678, 188743680);
    send_coord(-12345678, -188743680);
    send_coord(LON_MAX - 1, 419430);
    random_run(150);
    drain();

    // sphere
    write_reg(3'd0, 32'd0);
    pole_cases();
    random_run(140);
    drain();

    // largest eccentricity
    write_reg(3'd0, 32'hFFFF_FFFF);
    pole_cases();
    random_run(140);
    drain();

    // random eccentricity, then an unmapped address that must leave it alone
    write_reg(3'd0, $urandom);
    write_reg(3'd4, $urandom);
    random_run(100);
    drain();

    write_reg(3'd0, ECC_RESET);
    random_run(70);
    drain();

    repeat (1000) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: mercator_forward_projection_unit.f
sv/mfp_pkg.sv
sv/mfp_mulq.sv
sv/mfp_cdiv.sv
sv/mfp_divr.sv
sv/mfp_ln.sv
sv/mercator_forward_projection_unit.sv
tb/sv/mercator_forward_projection_unit_chk.sv
tb/sv/mercator_forward_projection_unit_tb.sv
